### sv/sorted_priority_queue_macros.svh
// Assertion helpers for the priority queue RTL.
`ifndef SORTED_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_MACROS_SVH

// Clocked assertion, disabled while the given active-low reset is low.
`define SPQ_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the block's own clock and reset.
`define SPQ_ASSERT(label, prop, msg) \
  `SPQ_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

### sv/spq_pkg.sv
package spq_pkg;

  localparam int unsigned DEPTH_DEF         = 16;
  localparam int unsigned PAYLOAD_WIDTH_DEF = 32;

  localparam int unsigned IN_PAYLOAD_W = 32;
  localparam int unsigned PRIO_W       = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned OCC_W        = 5;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // Broadcast from the control to every cell.
  typedef struct packed {
    logic                     enq;   // successful enqueue this cycle
    logic                     deq;   // successful dequeue this cycle
    logic signed [PRIO_W-1:0] prio;  // priority of the incoming entry
  } cell_ctrl_t;

endpackage

### sv/spq_if.sv
interface spq_req_if;
  logic                                   valid;
  logic                                   ready;
  spq_pkg::opcode_e                       opcode;
  logic        [spq_pkg::IN_PAYLOAD_W-1:0] payload;
  logic signed [spq_pkg::PRIO_W-1:0]       priority_req;

  modport source (output valid, opcode, payload, priority_req, input ready);
  modport sink   (input valid, opcode, payload, priority_req, output ready);
endinterface

interface spq_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [spq_pkg::IN_PAYLOAD_W-1:0]  out_payload;
  spq_pkg::status_e                  status;
  logic [spq_pkg::OCC_W-1:0]         occupancy;

  modport source (output valid, out_payload, status, occupancy, input ready);
  modport sink   (input valid, out_payload, status, occupancy, output ready);
endinterface

### sv/spq_cell.sv
// One slot of the sorted row; shifts right on insert, left on removal.
module spq_cell #(
  parameter int unsigned PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic                              clk_i,
  input  spq_pkg::cell_ctrl_t               ctrl_i,
  input  logic [PAYLOAD_WIDTH-1:0]          new_payload_i,
  input  logic                              occupied_i,
  input  logic                              left_take_i,
  input  logic [PAYLOAD_WIDTH-1:0]          left_payload_i,
  input  logic signed [spq_pkg::PRIO_W-1:0] left_prio_i,
  input  logic [PAYLOAD_WIDTH-1:0]          right_payload_i,
  input  logic signed [spq_pkg::PRIO_W-1:0] right_prio_i,
  output logic                              take_o,
  output logic [PAYLOAD_WIDTH-1:0]          payload_o,
  output logic signed [spq_pkg::PRIO_W-1:0] prio_o
);

  logic [PAYLOAD_WIDTH-1:0]          payload_q, payload_d;
  logic signed [spq_pkg::PRIO_W-1:0] prio_q, prio_d;

  // Slot is at or behind the insertion point.
  assign take_o = !occupied_i || (prio_q < ctrl_i.prio);

  always_comb begin
    payload_d = payload_q;
    prio_d    = prio_q;
    if (ctrl_i.enq) begin
      if (left_take_i) begin
        payload_d = left_payload_i;
        prio_d    = left_prio_i;
      end else if (take_o) begin
        payload_d = new_payload_i;
        prio_d    = ctrl_i.prio;
      end
    end else if (ctrl_i.deq) begin
      payload_d = right_payload_i;
      prio_d    = right_prio_i;
    end
  end

  always_ff @(posedge clk_i) begin
    payload_q <= payload_d;
    prio_q    <= prio_d;
  end

  assign payload_o = payload_q;
  assign prio_o    = prio_q;

endmodule

### sv/sorted_priority_queue.sv
// Channel | Dir | Fields                               | Transfer when
// req_i   | in  | opcode, payload, priority_req        | valid && ready
// rsp_o   | out | out_payload, status, occupancy       | valid && ready
//
// One item per cycle: each cell compares its priority with the incoming one
// and takes its left neighbour, the new entry or its right neighbour in the
// same cycle, so the whole row updates at once.
// The result sits in one output register; req_i.ready drops only while that
// register holds a result that rsp_o has not taken.
// Reset (rst_ni, async, active low) clears the entry count and the output
// valid; slot contents are never read before they are written.
module sorted_priority_queue #(
  parameter int unsigned DEPTH         = spq_pkg::DEPTH_DEF,
  parameter int unsigned PAYLOAD_WIDTH = spq_pkg::PAYLOAD_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spq_req_if.sink   req_i,
  spq_rsp_if.source rsp_o
);

  `include "sorted_priority_queue_macros.svh"

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  // entry count; slots below it hold valid entries, front at slot 0
  logic [CntW-1:0] count_q, count_d;

  logic                              out_valid_q;
  logic [spq_pkg::IN_PAYLOAD_W-1:0]  out_payload_q, out_payload_d;
  spq_pkg::status_e                  status_q, status_d;
  logic [spq_pkg::OCC_W-1:0]         occupancy_q;

  logic accept, full, empty, is_enq, is_deq;
  spq_pkg::cell_ctrl_t ctrl;
  logic [PAYLOAD_WIDTH-1:0] new_payload;

  logic [DEPTH-1:0]                  take;
  logic [DEPTH-1:0]                  occupied;
  logic [PAYLOAD_WIDTH-1:0]          cell_payload [DEPTH];
  logic signed [spq_pkg::PRIO_W-1:0] cell_prio    [DEPTH];
  logic                              sort_ok;

  // Output register frees up as soon as the sink takes its result.
  assign req_i.ready = !out_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full   = (count_q == CntW'(DEPTH));
  assign empty  = (count_q == '0);
  assign is_enq = accept && (req_i.opcode == spq_pkg::OP_ENQ);
  assign is_deq = accept && (req_i.opcode == spq_pkg::OP_DEQ);

  // Dropped or empty operations leave the row untouched.
  assign ctrl.enq    = is_enq && !full;
  assign ctrl.deq    = is_deq && !empty;
  assign ctrl.prio   = req_i.priority_req;
  assign new_payload = PAYLOAD_WIDTH'(req_i.payload);

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                              left_take;
    logic [PAYLOAD_WIDTH-1:0]          left_payload, right_payload;
    logic signed [spq_pkg::PRIO_W-1:0] left_prio, right_prio;

    assign occupied[i] = (CntW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left_take    = 1'b0;
      assign left_payload = new_payload;
      assign left_prio    = ctrl.prio;
    end else begin : g_body
      assign left_take    = take[i-1];
      assign left_payload = cell_payload[i-1];
      assign left_prio    = cell_prio[i-1];
    end

    // tail slot refills with itself on removal; it is then beyond the count
    if (i == DEPTH - 1) begin : g_tail
      assign right_payload = cell_payload[i];
      assign right_prio    = cell_prio[i];
    end else begin : g_inner
      assign right_payload = cell_payload[i+1];
      assign right_prio    = cell_prio[i+1];
    end

    spq_cell #(
      .PAYLOAD_WIDTH(PAYLOAD_WIDTH)
    ) u_cell (
      .clk_i          (clk_i),
      .ctrl_i         (ctrl),
      .new_payload_i  (new_payload),
      .occupied_i     (occupied[i]),
      .left_take_i    (left_take),
      .left_payload_i (left_payload),
      .left_prio_i    (left_prio),
      .right_payload_i(right_payload),
      .right_prio_i   (right_prio),
      .take_o         (take[i]),
      .payload_o      (cell_payload[i]),
      .prio_o         (cell_prio[i])
    );
  end

  always_comb begin
    count_d       = count_q;
    out_payload_d = '0;
    status_d      = spq_pkg::ST_DONE;
    if (is_enq) begin
      if (full) begin
        status_d = spq_pkg::ST_FULL;
      end else begin
        count_d = count_q + CntW'(1);
      end
    end else if (is_deq) begin
      if (empty) begin
        status_d = spq_pkg::ST_EMPTY;
      end else begin
        count_d       = count_q - CntW'(1);
        out_payload_d = spq_pkg::IN_PAYLOAD_W'(cell_payload[0]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_payload_q <= out_payload_d;
      status_q      <= status_d;
      occupancy_q   <= spq_pkg::OCC_W'(count_d);
    end
  end

  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.out_payload = out_payload_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.occupancy   = occupancy_q;

  // Valid slots never rise in priority towards the tail.
  always_comb begin
    sort_ok = 1'b1;
    for (int unsigned k = 1; k < DEPTH; k++) begin
      if (occupied[k] && (cell_prio[k] > cell_prio[k-1])) begin
        sort_ok = 1'b0;
      end
    end
  end

  `SPQ_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "entry count beyond depth")
  `SPQ_ASSERT(a_sorted, sort_ok, "row out of priority order")
  `SPQ_ASSERT(a_enq_grow, ctrl.enq |=> count_q == CntW'($past(count_q) + CntW'(1)), "enqueue lost")
  `SPQ_ASSERT(a_empty_deq, is_deq && empty |=> status_q == spq_pkg::ST_EMPTY, "empty status missing")
  `SPQ_ASSERT(a_full_hold, is_enq && full |=> count_q == CntW'(DEPTH), "full enqueue changed count")

endmodule
